// ===== hw/rtl/sphere_glyph_vertex_generator_top_assert.svh =====
// Assertion macros used by the sphere glyph vertex generator sequencer (sgvg_ctrl).
`ifndef SPHERE_GLYPH_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define SPHERE_GLYPH_VERTEX_GENERATOR_TOP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SGVG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define SGVG_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sgvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvg_pkg
// Types, codes and fixed-point helpers of the sphere glyph vertex generator.
// ----------------------------------------------------------------------------
package sgvg_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] data_u;
		logic signed [31:0] data_v;
		logic signed [31:0] data_w;
		logic [31:0]        point_color;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic [31:0]        vertex_color;
		logic [4:0]         local_vertex;
		logic [20:0]        global_vertex;
		logic               last_vertex;
	} out_beat_t;

	// multiplier operation codes, consecutive in issue order
	localparam logic [3:0] OP_F  = 4'd0;
	localparam logic [3:0] OP_SX = 4'd1;
	localparam logic [3:0] OP_SY = 4'd2;
	localparam logic [3:0] OP_SZ = 4'd3;
	localparam logic [3:0] OP_TX = 4'd4;
	localparam logic [3:0] OP_TY = 4'd5;
	localparam logic [3:0] OP_TZ = 4'd6;
	localparam logic [3:0] OP_S  = 4'd7;
	localparam logic [3:0] OP_OX = 4'd8;
	localparam logic [3:0] OP_OY = 4'd9;
	localparam logic [3:0] OP_OZ = 4'd10;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_RADIUS = 2'd1;
	localparam logic [1:0] CFG_SCALE  = 2'd2;
	localparam logic [1:0] CFG_COLOR  = 2'd3;

	localparam logic [1:0] MODE_DATA   = 2'd1;
	localparam logic [1:0] MODE_DEFORM = 2'd2;

	localparam logic [4:0] LAST_VTX = 5'd16;

	typedef struct packed {
		logic       load_in;
		logic       op_en;
		logic [3:0] op;
		logic       load_out;
		logic [4:0] vtx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic deform;
		logic out_busy;
	} sts_t;

	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647)       r = 32'sh7fffffff;
		else if (v < -48'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)       r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	// Q16.16 product, round half up, saturate
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd32768;
		return sat48(p[63:16]);
	endfunction

	function automatic logic signed [31:0] unit_x(input logic [4:0] k);
		logic signed [31:0] r;
		case (k)
			5'd0:  r = 32'sd65536;
			5'd1, 5'd4: r = 32'sd20252;
			5'd2, 5'd3: r = -32'sd53020;
			5'd5, 5'd9, 5'd10, 5'd14: r = 32'sd37491;
			5'd6, 5'd8, 5'd11, 5'd13: r = -32'sd14320;
			5'd7, 5'd12: r = -32'sd46341;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] unit_y(input logic [4:0] k);
		logic signed [31:0] r;
		case (k)
			5'd1: r = 32'sd62328;
			5'd2: r = 32'sd38521;
			5'd3: r = -32'sd38521;
			5'd4: r = -32'sd62328;
			5'd5, 5'd10: r = 32'sd27239;
			5'd6, 5'd11: r = 32'sd44073;
			5'd8, 5'd13: r = -32'sd44073;
			5'd9, 5'd14: r = -32'sd27239;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] unit_z(input logic [4:0] k);
		logic signed [31:0] r;
		case (k)
			5'd5, 5'd6, 5'd7, 5'd8, 5'd9: r = 32'sd46341;
			5'd10, 5'd11, 5'd12, 5'd13, 5'd14: r = -32'sd46341;
			5'd15: r = 32'sd65536;
			5'd16: r = -32'sd65536;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/sgvg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvg_ctrl
// Sequencer: steps the shared multiplier and emits one vertex at a time.
// ----------------------------------------------------------------------------
`include "sphere_glyph_vertex_generator_top_assert.svh"
module sgvg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sgvg_pkg::sts_t sts,
	output sgvg_pkg::cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_F    = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [3:0] op_q;
	logic [4:0] vtx_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.vtx      = vtx_q;
		cmd.op       = op_q;
		cmd.last     = (vtx_q == sgvg_pkg::LAST_VTX);
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.op_en    = (state_q == ST_F) || (state_q == ST_CALC);
		cmd.load_out = (state_q == ST_EMIT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= sgvg_pkg::OP_F;
			vtx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_F;
						op_q    <= sgvg_pkg::OP_F;
						vtx_q   <= '0;
					end
				end
				ST_F: begin
					state_q <= ST_CALC;
					op_q    <= sgvg_pkg::OP_SX;
				end
				ST_CALC: begin
					if ((op_q == sgvg_pkg::OP_SZ && !sts.deform) ||
						op_q == sgvg_pkg::OP_OZ) begin
						state_q <= ST_EMIT;
					end else begin
						op_q <= op_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (!sts.out_busy) begin
						if (vtx_q == sgvg_pkg::LAST_VTX) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_CALC;
							op_q    <= sgvg_pkg::OP_SX;
							vtx_q   <= vtx_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SGVG_ASSERT(a_load_out_free, clk, arst_n, cmd.load_out |-> !sts.out_busy, "load into busy output")
	`SGVG_ASSERT(a_accept_to_f, clk, arst_n, cmd.load_in |=> (state_q == ST_F), "accept not followed by factor step")
	`SGVG_NEVER(a_vtx_range, clk, arst_n, vtx_q > sgvg_pkg::LAST_VTX, "vertex index out of range")
	`SGVG_ASSERT(a_emit_ops, clk, arst_n, (state_q == ST_EMIT) |-> (op_q == sgvg_pkg::OP_SZ || op_q == sgvg_pkg::OP_OZ), "emit before products done")

endmodule

// ===== hw/rtl/sgvg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgvg_dp
// Datapath: config registers, shared Q16.16 multiplier, vertex assembly.
// ----------------------------------------------------------------------------
module sgvg_dp #(
	parameter int MAX_POINTS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  sgvg_pkg::in_beat_t  in_data,
	input  sgvg_pkg::cmd_t      cmd,
	output sgvg_pkg::sts_t      sts,
	output logic                out_valid,
	input  logic                out_stall,
	output sgvg_pkg::out_beat_t out_data
);
	localparam int WRAP = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;

	logic [1:0]         mode_q;
	logic signed [31:0] radius_q, scale_q;
	logic               color_en_q;
	logic [15:0]        pcnt_q;
	sgvg_pkg::in_beat_t pt_q;
	logic signed [31:0] f_q, sx_q, sy_q, sz_q, s_q, ox_q, oy_q, oz_q;
	logic signed [33:0] t_q;
	logic               out_valid_q;
	sgvg_pkg::out_beat_t out_q;

	logic signed [31:0] ux, uy, uz, ma, mb, prod, tsat, tsel;
	logic [16:0]        pnext;

	assign ux = sgvg_pkg::unit_x(cmd.vtx);
	assign uy = sgvg_pkg::unit_y(cmd.vtx);
	assign uz = sgvg_pkg::unit_z(cmd.vtx);

	assign sts.deform   = (mode_q == sgvg_pkg::MODE_DEFORM) && (radius_q != 32'sd0);
	assign sts.out_busy = out_valid_q && out_stall;

	assign tsat = sgvg_pkg::sat34(t_q);
	assign tsel = !radius_q[31] ? tsat :
		(tsat == 32'sh80000000) ? 32'sh7fffffff : -tsat;

	always_comb begin
		ma = scale_q;
		mb = pt_q.data_u;
		case (cmd.op)
			sgvg_pkg::OP_SX: begin ma = (mode_q == sgvg_pkg::MODE_DATA) ? f_q : radius_q; mb = ux; end
			sgvg_pkg::OP_SY: begin ma = (mode_q == sgvg_pkg::MODE_DATA) ? f_q : radius_q; mb = uy; end
			sgvg_pkg::OP_SZ: begin ma = (mode_q == sgvg_pkg::MODE_DATA) ? f_q : radius_q; mb = uz; end
			sgvg_pkg::OP_TX: begin ma = ux; mb = pt_q.data_u; end
			sgvg_pkg::OP_TY: begin ma = uy; mb = pt_q.data_v; end
			sgvg_pkg::OP_TZ: begin ma = uz; mb = pt_q.data_w; end
			sgvg_pkg::OP_S:  begin ma = scale_q; mb = tsel; end
			sgvg_pkg::OP_OX: begin ma = pt_q.data_u; mb = s_q; end
			sgvg_pkg::OP_OY: begin ma = pt_q.data_v; mb = s_q; end
			sgvg_pkg::OP_OZ: begin ma = pt_q.data_w; mb = s_q; end
			default: begin ma = scale_q; mb = pt_q.data_u; end
		endcase
	end

	assign prod  = sgvg_pkg::mulq(ma, mb);
	assign pnext = {1'b0, pcnt_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			radius_q    <= 32'sd65536;
			scale_q     <= 32'sd65536;
			color_en_q  <= 1'b0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sgvg_pkg::CFG_MODE:   mode_q     <= cfg_data[1:0];
					sgvg_pkg::CFG_RADIUS: radius_q   <= cfg_data;
					sgvg_pkg::CFG_SCALE:  scale_q    <= cfg_data;
					sgvg_pkg::CFG_COLOR:  color_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				if (cmd.last) begin
					pcnt_q <= (pnext >= 17'(WRAP)) ? 16'd0 : pnext[15:0];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pt_q <= in_data;
		end
		if (cmd.op_en) begin
			case (cmd.op)
				sgvg_pkg::OP_F: f_q <= prod;
				sgvg_pkg::OP_SX: begin
					sx_q <= prod;
					ox_q <= '0;
					oy_q <= '0;
					oz_q <= '0;
				end
				sgvg_pkg::OP_SY: sy_q <= prod;
				sgvg_pkg::OP_SZ: sz_q <= prod;
				sgvg_pkg::OP_TX: t_q  <= 34'(prod);
				sgvg_pkg::OP_TY: t_q  <= t_q + 34'(prod);
				sgvg_pkg::OP_TZ: t_q  <= t_q + 34'(prod);
				sgvg_pkg::OP_S:  s_q  <= prod;
				sgvg_pkg::OP_OX: ox_q <= prod;
				sgvg_pkg::OP_OY: oy_q <= prod;
				sgvg_pkg::OP_OZ: oz_q <= prod;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			out_q.vert_x <= sgvg_pkg::sat34(34'(pt_q.pos_x) + 34'(sx_q) + 34'(ox_q));
			out_q.vert_y <= sgvg_pkg::sat34(34'(pt_q.pos_y) + 34'(sy_q) + 34'(oy_q));
			out_q.vert_z <= sgvg_pkg::sat34(34'(pt_q.pos_z) + 34'(sz_q) + 34'(oz_q));
			out_q.norm_x <= sgvg_pkg::sat34(34'(ux) - 34'(ox_q));
			out_q.norm_y <= sgvg_pkg::sat34(34'(uy) - 34'(oy_q));
			out_q.norm_z <= sgvg_pkg::sat34(34'(uz) - 34'(oz_q));
			out_q.vertex_color  <= color_en_q ? pt_q.point_color : 32'd0;
			out_q.local_vertex  <= cmd.vtx;
			out_q.global_vertex <= ({5'd0, pcnt_q} << 4) + {5'd0, pcnt_q} + {16'd0, cmd.vtx};
			out_q.last_vertex   <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/sphere_glyph_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// Vertices are built on the single shared 32x32 multiplier, one product at a time: a factor
// step per point, then per vertex the scale products and, in deform mode with nonzero radius,
// the dot product, factor and offset products. A point takes 17 vertices.
// One point at a time; the next point is accepted once the previous point's last vertex is in the output reg.
// Reset (arst_n low, async): mode 0, radius and scale 1.0, color off, point count 0.
// ----------------------------------------------------------------------------
// sphere_glyph_vertex_generator_top
// Emits the 17 vertices of a sphere glyph for every accepted point.
// ----------------------------------------------------------------------------
module sphere_glyph_vertex_generator_top #(
	parameter int MAX_POINTS = 65536 // point number wraps here (capped at 65536)
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	// point input beats
	input  logic                in_valid,
	output logic                in_stall,
	input  sgvg_pkg::in_beat_t  in_data,
	// vertex output beats
	output logic                out_valid,
	input  logic                out_stall,
	output sgvg_pkg::out_beat_t out_data
);
	// controller drives command, datapath reports status
	sgvg_pkg::cmd_t cmd;
	sgvg_pkg::sts_t sts;

	// sequencer: factor step, then per vertex the scale products and,
	// in deform mode with nonzero radius, the dot product, factor and offset products
	sgvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// registers, shared multiplier and the output beat register
	sgvg_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sphere glyph vertex generator: a local predictor builds the 17
// vertices of every accepted point and each output beat is compared field by
// field against the oldest prediction, across modes, register extremes and
// random input/output idling.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int GLYPH_VERTS = 17;
	localparam int WATCHDOG = 20000;
	localparam int MAX_POINTS = 65536;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	sgvg_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	sgvg_pkg::out_beat_t out_data;

	sphere_glyph_vertex_generator_top #(
		.MAX_POINTS(MAX_POINTS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// predictor copy of the block's registers and point counter
	logic [1:0] glyph_mode;
	logic signed [31:0] glyph_radius;
	logic signed [31:0] glyph_scale;
	logic glyph_color_en;
	logic [15:0] point_num;

	sgvg_pkg::out_beat_t vertex_queue[$];
	int err_count = 0;
	int points_sent = 0;
	int verts_seen = 0;
	int idle_cycles = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	bit hold_output = 0;

	function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q16.16 product, round half toward +inf, saturated
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd32768;
		return clamp64(p >>> 16);
	endfunction

	// sphere unit table, coordinate c of vertex k
	function automatic logic signed [31:0] sphere_unit(input int k, input int c);
		int ux[17] = '{65536, 20252, -53020, -53020, 20252, 37491, -14320, -46341,
			-14320, 37491, 37491, -14320, -46341, -14320, 37491, 0, 0};
		int uy[17] = '{0, 62328, 38521, -38521, -62328, 27239, 44073, 0, -44073,
			-27239, 27239, 44073, 0, -44073, -27239, 0, 0};
		int uz[17] = '{0, 0, 0, 0, 0, 46341, 46341, 46341, 46341, 46341, -46341,
			-46341, -46341, -46341, -46341, 65536, -65536};
		if (c == 0) return ux[k];
		if (c == 1) return uy[k];
		return uz[k];
	endfunction

	task automatic predict_glyph(input sgvg_pkg::in_beat_t pt);
		logic signed [31:0] f, t, s;
		logic signed [31:0] u[3], sc[3], off[3], vec[3], pos[3], vp[3], np[3];
		sgvg_pkg::out_beat_t v;
		f = qmul(glyph_scale, pt.data_u);
		vec = '{pt.data_u, pt.data_v, pt.data_w};
		pos = '{pt.pos_x, pt.pos_y, pt.pos_z};
		for (int k = 0; k < GLYPH_VERTS; k++) begin
			for (int c = 0; c < 3; c++) begin
				u[c] = sphere_unit(k, c);
				off[c] = 0;
				sc[c] = (glyph_mode == sgvg_pkg::MODE_DATA) ? qmul(u[c], f)
					: qmul(glyph_radius, u[c]);
			end
			if (glyph_mode == sgvg_pkg::MODE_DEFORM && glyph_radius != 0) begin
				t = clamp64(64'(qmul(u[0], vec[0])) + 64'(qmul(u[1], vec[1]))
					+ 64'(qmul(u[2], vec[2])));
				if (glyph_radius < 0) t = clamp64(-64'(t));
				s = qmul(glyph_scale, t);
				for (int c = 0; c < 3; c++) off[c] = qmul(vec[c], s);
			end
			for (int c = 0; c < 3; c++) begin
				vp[c] = clamp64(64'(pos[c]) + 64'(sc[c]) + 64'(off[c]));
				np[c] = clamp64(64'(u[c]) - 64'(off[c]));
			end
			v.vert_x = vp[0]; v.vert_y = vp[1]; v.vert_z = vp[2];
			v.norm_x = np[0]; v.norm_y = np[1]; v.norm_z = np[2];
			v.vertex_color = glyph_color_en ? pt.point_color : 32'd0;
			v.local_vertex = 5'(k);
			v.global_vertex = 21'(32'(point_num) * GLYPH_VERTS + k);
			v.last_vertex = (k == GLYPH_VERTS - 1);
			vertex_queue.push_back(v);
		end
		point_num = (32'(point_num) + 1 >= MAX_POINTS) ? 16'd0 : point_num + 16'd1;
	endtask

	// one register write; block must be idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sgvg_pkg::CFG_MODE: glyph_mode = val[1:0];
			sgvg_pkg::CFG_RADIUS: glyph_radius = val;
			sgvg_pkg::CFG_SCALE: glyph_scale = val;
			default: glyph_color_en = val[0];
		endcase
		@(posedge clk);
	endtask

	// send one point beat, with optional random idle before it
	task automatic send_point(input sgvg_pkg::in_beat_t pt);
		while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= pt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_glyph(pt);
		points_sent++;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (vertex_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff; // small Q16.16
			3: return $urandom_range(0, 32'h3ffffff) - 32'h1ffffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic sgvg_pkg::in_beat_t rand_point();
		sgvg_pkg::in_beat_t p;
		p.pos_x = rand_field(); p.pos_y = rand_field(); p.pos_z = rand_field();
		p.data_u = rand_field(); p.data_v = rand_field(); p.data_w = rand_field();
		if ($urandom_range(9) == 0) begin
			p.data_u = 0; p.data_v = 0; p.data_w = 0;
		end
		p.point_color = $urandom;
		return p;
	endfunction

	// output stall generator
	always @(posedge clk) begin
		if (hold_output) out_stall <= 1'b1;
		else out_stall <= (out_stall_pct > 0) && ($urandom_range(99) < out_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verts_seen++;
			if (vertex_queue.size() == 0) begin
				$error("unexpected vertex beat global_vertex=%0d", out_data.global_vertex);
				err_count++;
			end else begin
				sgvg_pkg::out_beat_t e;
				e = vertex_queue.pop_front();
				if (e.vert_x !== out_data.vert_x) begin
					$error("vert_x exp %h got %h", e.vert_x, out_data.vert_x); err_count++;
				end
				if (e.vert_y !== out_data.vert_y) begin
					$error("vert_y exp %h got %h", e.vert_y, out_data.vert_y); err_count++;
				end
				if (e.vert_z !== out_data.vert_z) begin
					$error("vert_z exp %h got %h", e.vert_z, out_data.vert_z); err_count++;
				end
				if (e.norm_x !== out_data.norm_x) begin
					$error("norm_x exp %h got %h", e.norm_x, out_data.norm_x); err_count++;
				end
				if (e.norm_y !== out_data.norm_y) begin
					$error("norm_y exp %h got %h", e.norm_y, out_data.norm_y); err_count++;
				end
				if (e.norm_z !== out_data.norm_z) begin
					$error("norm_z exp %h got %h", e.norm_z, out_data.norm_z); err_count++;
				end
				if (e.vertex_color !== out_data.vertex_color) begin
					$error("vertex_color exp %h got %h", e.vertex_color,
						out_data.vertex_color); err_count++;
				end
				if (e.local_vertex !== out_data.local_vertex) begin
					$error("local_vertex exp %0d got %0d", e.local_vertex,
						out_data.local_vertex); err_count++;
				end
				if (e.global_vertex !== out_data.global_vertex) begin
					$error("global_vertex exp %0d got %0d", e.global_vertex,
						out_data.global_vertex); err_count++;
				end
				if (e.last_vertex !== out_data.last_vertex) begin
					$error("last_vertex exp %0d got %0d", e.last_vertex,
						out_data.last_vertex); err_count++;
				end
			end
		end
	end

	// watchdog: cycles with no beat moving on either side; a deliberate long
	// output hold also counts, so the limit covers it
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG);
			$display("tb_top: errors");
			$finish;
		end
	end

	// ---- tests ----

	// extremes and special cases under the default registers, then each mode
	task automatic test_directed();
		sgvg_pkg::in_beat_t p;
		p = '0;
		send_point(p);
		p.pos_x = 32'h7fffffff; p.pos_y = 32'h80000000; p.pos_z = 32'h7fffffff;
		p.point_color = 32'hffffffff;
		send_point(p);
		wait_drained();
		write_reg(sgvg_pkg::CFG_COLOR, 32'd1);
		for (int m = 0; m < 4; m++) begin
			write_reg(sgvg_pkg::CFG_MODE, 32'(m));
			p = '0; p.data_u = 32'h00020000; p.data_v = 32'hffff0000; p.data_w = 32'h00008000;
			p.point_color = 32'ha5a55a5a;
			send_point(p);
			p.data_u = 0; p.data_v = 0; p.data_w = 0; // zero vector
			send_point(p);
			p.pos_x = 32'h80000000; p.pos_y = 32'h7fffffff; p.pos_z = 32'h80000000;
			p.data_u = 32'h7fffffff; p.data_v = 32'h80000000; p.data_w = 32'h7fffffff;
			p.point_color = 32'h5a5aa5a5;
			send_point(p);
			wait_drained();
		end
		// radius zero and negative in deform mode, extreme scale
		write_reg(sgvg_pkg::CFG_MODE, {30'd0, sgvg_pkg::MODE_DEFORM});
		write_reg(sgvg_pkg::CFG_RADIUS, 32'd0);
		p = '0; p.data_u = 32'h00010000; p.data_v = 32'h00010000; p.data_w = 32'h00010000;
		send_point(p);
		wait_drained();
		write_reg(sgvg_pkg::CFG_RADIUS, 32'hffff0000);
		write_reg(sgvg_pkg::CFG_SCALE, 32'h80000000);
		send_point(p);
		wait_drained();
		write_reg(sgvg_pkg::CFG_RADIUS, 32'h80000000);
		write_reg(sgvg_pkg::CFG_SCALE, 32'h7fffffff);
		send_point(p);
		p.data_u = 32'h7fffffff; p.data_v = 32'h7fffffff; p.data_w = 32'h80000000;
		send_point(p);
		wait_drained();
	endtask

	// random points over a set of register settings and idling phases
	task automatic test_random(input int n_points);
		int phase;
		for (int i = 0; i < n_points; i++) begin
			if (i % 20 == 0) begin
				wait_drained();
				phase = (i / 20) % 4;
				in_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 81 : 28) : 0;
				out_stall_pct = (phase == 2) ? 81 : (phase == 3 ? 28 : 0);
				write_reg(sgvg_pkg::CFG_MODE, $urandom_range(3));
				write_reg(sgvg_pkg::CFG_RADIUS, ($urandom_range(3) == 0) ? rand_field()
					: $urandom_range(0, 32'h3ffff) - 32'h1ffff);
				write_reg(sgvg_pkg::CFG_SCALE, ($urandom_range(3) == 0) ? rand_field()
					: $urandom_range(0, 32'h3ffff) - 32'h1ffff);
				write_reg(sgvg_pkg::CFG_COLOR, $urandom_range(1));
			end
			send_point(rand_point());
		end
		wait_drained();
		in_idle_pct = 0;
		out_stall_pct = 0;
	endtask

	// hold the output for a long stretch while points keep coming
	task automatic test_backpressure();
		write_reg(sgvg_pkg::CFG_MODE, 32'd0);
		fork
			begin
				hold_output = 1;
				repeat (400) @(posedge clk);
				hold_output = 0;
			end
			for (int i = 0; i < 4; i++) send_point(rand_point());
		join
		wait_drained(); // sender pauses until every vertex has come
		for (int i = 0; i < 3; i++) send_point(rand_point());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		glyph_mode = 2'd0; glyph_radius = 32'sd65536; glyph_scale = 32'sd65536;
		glyph_color_en = 1'b0; point_num = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(200);
		repeat (50) @(posedge clk);
		$display("covered %0d points and %0d vertex beats in all modes,", points_sent, verts_seen);
		$display("register extremes, zero radius/vector and input/output idling");
		if (err_count == 0 && vertex_queue.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
